### hdl/wra_pkg.sv
// ----------------------------------------------------------------------------
// wra_pkg
// shared constants, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package wra_pkg;

    // fixed field widths
    localparam int WLEN_BITS       = 11;
    localparam int CFG_IDX_BITS    = 1;

    // defaults for the top level parameters
    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int DEF_SAMPLE_BITS = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_VALUE = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic restart;    // refill window, latch length and fill value
        logic capture;    // take the sample of an accepted request
        logic read;       // read the ring slot at the write position
        logic update;     // update sum, overwrite slot, advance position
        logic div_start;  // start dividing the running sum
        logic take_quot;  // move the quotient into the result register
        logic load_out;   // move the result into the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;   // quotient ready this cycle
    } sts_t;

endpackage

`default_nettype wire

### hdl/wra_div.sv
// ----------------------------------------------------------------------------
// wra_div
// sequential signed divide of the running sum by the window length, one bit
// per cycle, quotient truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module wra_div #(
    parameter int SUM_BITS    = wra_pkg::DEF_SAMPLE_BITS + wra_pkg::WLEN_BITS,
    parameter int SAMPLE_BITS = wra_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [SUM_BITS-1:0]          dividend,
    input  wire logic        [wra_pkg::WLEN_BITS-1:0] divisor,
    output logic                                     done,
    output logic signed [SAMPLE_BITS-1:0]            quotient
);

    localparam int WB       = wra_pkg::WLEN_BITS;
    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [SUM_BITS-1:0] mag_reg, mag_next;
    logic [WB-1:0]       rem_reg, rem_next;
    logic [WB-1:0]       dvs_reg, dvs_next;

    logic [WB:0]         trial;
    logic [WB:0]         diff;
    logic                fits;
    logic [SUM_BITS-1:0] abs_val;
    logic [SUM_BITS-1:0] signed_q;

    assign abs_val = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
    assign trial   = {rem_reg, mag_reg[SUM_BITS-1]};
    assign diff    = trial - {1'b0, dvs_reg};
    assign fits    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(SUM_BITS);
            neg_next  = dividend[SUM_BITS-1];
            mag_next  = abs_val;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // restoring step, quotient bits shift in where dividend bits leave
            rem_next = fits ? diff[WB-1:0] : trial[WB-1:0];
            mag_next = {mag_reg[SUM_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign signed_q = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign quotient = signed_q[SAMPLE_BITS-1:0];
    assign done     = done_reg;

`ifndef ASSERT_OFF
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divide started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("quotient flagged without a finished divide");
`endif

endmodule

`default_nettype wire

### hdl/wra_dp.sv
// ----------------------------------------------------------------------------
// wra_dp
// datapath: configuration registers, sample ring, running sum, write
// position, divider and result/output registers
// ----------------------------------------------------------------------------
`default_nettype none

module wra_dp #(
    parameter int MAX_WINDOW  = wra_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wra_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [wra_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [((SAMPLE_BITS > wra_pkg::WLEN_BITS) ? SAMPLE_BITS
                        : wra_pkg::WLEN_BITS)-1:0]    cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire wra_pkg::cmd_t                       cmd,
    output wra_pkg::sts_t                            sts,
    output logic signed [SAMPLE_BITS-1:0]            average,
    output logic [wra_pkg::WLEN_BITS-1:0]            window_count
);

    localparam int WB       = wra_pkg::WLEN_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + WB;
    localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // configuration
    logic [WB-1:0]                 wlen_cfg_reg;
    logic signed [SAMPLE_BITS-1:0] init_cfg_reg;

    // window state
    logic [WB-1:0]                 n_reg;
    logic signed [SAMPLE_BITS-1:0] init_q_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [AW-1:0]                 pos_reg;
    logic                          wrapped_reg;

    // payload
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] rd_q_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg;
    logic [WB-1:0]                 out_cnt_reg;

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

    logic [WB-1:0]                 eff_n;
    logic signed [SUM_BITS:0]      fill_prod;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic signed [SUM_BITS-1:0]    oldest_ext;
    logic signed [SUM_BITS-1:0]    sample_ext;
    logic                          last_slot;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] quotient;

    // zero means one, saturate at the ring depth
    always_comb
    begin
        priority if (wlen_cfg_reg == '0)
            eff_n = WB'(1);
        else if (32'(wlen_cfg_reg) > 32'(MAX_WINDOW))
            eff_n = WB'(MAX_WINDOW);
        else
            eff_n = wlen_cfg_reg;
    end

    assign fill_prod  = init_cfg_reg * $signed({1'b0, eff_n});
    // slots not yet written since restart hold the fill value
    assign oldest     = wrapped_reg ? rd_q_reg : init_q_reg;
    assign oldest_ext = SUM_BITS'(oldest);
    assign sample_ext = SUM_BITS'(sample_reg);
    assign last_slot  = (32'(pos_reg) + 32'd1) == 32'(n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_cfg_reg <= WB'(1);
            init_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == wra_pkg::REG_WINDOW_LENGTH)
                wlen_cfg_reg <= cfg_data[WB-1:0];
            if (cfg_index == wra_pkg::REG_INITIAL_VALUE)
                init_cfg_reg <= cfg_data[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= WB'(1);
            init_q_reg  <= '0;
            sum_reg     <= '0;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (cmd.restart)
        begin
            n_reg       <= eff_n;
            init_q_reg  <= init_cfg_reg;
            sum_reg     <= fill_prod[SUM_BITS-1:0];
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            sum_reg <= sum_reg - oldest_ext + sample_ext;
            if (last_slot)
            begin
                pos_reg     <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // ring store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            ring_mem[pos_reg] <= sample_reg;
        if (cmd.read)
            rd_q_reg <= ring_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sample_reg <= sample;
        if (cmd.restart)
            result_reg <= init_cfg_reg;
        else if (cmd.take_quot)
            result_reg <= quotient;
        if (cmd.load_out)
        begin
            out_avg_reg <= result_reg;
            out_cnt_reg <= n_reg;
        end
    end

    wra_div #(
        .SUM_BITS    (SUM_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.div_done = div_done;
    assign average      = out_avg_reg;
    assign window_count = out_cnt_reg;

`ifndef ASSERT_OFF
    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(n_reg))
        else $error("write position outside the window");

    a_n_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != '0) && (32'(n_reg) <= 32'(MAX_WINDOW)))
        else $error("latched window length out of range");
`endif

endmodule

`default_nettype wire

### hdl/wra_ctrl.sv
// ----------------------------------------------------------------------------
// wra_ctrl
// sequencing state machine for restart and sample requests
// ----------------------------------------------------------------------------
`default_nettype none

module wra_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output wra_pkg::cmd_t      cmd,
    input  wire wra_pkg::sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_START  = 3'd3;
    localparam logic [2:0] ST_DIVIDE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       s_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    cmd.take_quot = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("request accepted while previous one in progress");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result presented outside the finish step");
`endif

endmodule

`default_nettype wire

### hdl/windowed_running_average.sv
// ----------------------------------------------------------------------------
// windowed_running_average
// boxcar moving average over a run-time selected window of samples
// ----------------------------------------------------------------------------
// sequence: a sample request is answered after the ring read, the sum update
//   and a divide that finds one quotient bit per cycle over the
//   35-bit running sum in the divider; a restart request skips the divide
// requests: a new one is accepted only after the previous result is loaded out
// reset: rst_n clears at once; window length 1, fill value 0, no clearing
//   pass over the ring, slots read as the fill value until rewritten
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_running_average #(
    parameter int MAX_WINDOW  = wra_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wra_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // configuration writes, index 0 window_length, index 1 initial_value
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [((SAMPLE_BITS > wra_pkg::WLEN_BITS) ? SAMPLE_BITS
                        : wra_pkg::WLEN_BITS)-1:0]   cfg_data,

    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    input  wire logic                               s_tuser,        // restart

    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // average, window_count
    output logic [((SAMPLE_BITS + wra_pkg::WLEN_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W = ((SAMPLE_BITS + wra_pkg::WLEN_BITS + 7) / 8) * 8;

    wra_pkg::cmd_t                 cmd;
    wra_pkg::sts_t                 sts;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [wra_pkg::WLEN_BITS-1:0] window_count;

    // configuration is always taken; writes must only happen while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    wra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    wra_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (s_tdata[SAMPLE_BITS-1:0]),
        .cmd          (cmd),
        .sts          (sts),
        .average      (average),
        .window_count (window_count)
    );

    // average in the low bits, window count above, zero fill to bytes
    assign m_tdata = OUT_W'({window_count, average});

endmodule

`default_nettype wire
